// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the unescaper core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on the rising clock, masked while reset is held.
`define JSU_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Check a property on the rising clock, also during reset.
`define JSU_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define JSU_ASSERT(label, clk, rst_n, prop)
`define JSU_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- rtl/core/jsu_pkg.sv -----
// Shared types for the JSON string unescaper.
package jsu_pkg;

    // Result kinds as carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // Error codes as carried in the output tdata.
    typedef enum logic [3:0] {
        ERR_NONE           = 4'd0,
        ERR_NO_QUOTE       = 4'd1,
        ERR_CONTROL        = 4'd2,
        ERR_BAD_ESCAPE     = 4'd3,
        ERR_NON_HEX        = 4'd4,
        ERR_UNPAIRED_HIGH  = 4'd5,
        ERR_BAD_PAIR       = 4'd6,
        ERR_UNPAIRED_LOW   = 4'd7,
        ERR_ESC_INCOMPLETE = 4'd8,
        ERR_UNI_INCOMPLETE = 4'd9,
        ERR_UNTERMINATED   = 4'd10
    } err_t;

    // Command from the parser to the emitter: one code point, a done or an error.
    // len is the number of UTF-8 bytes minus one.
    typedef struct packed {
        kind_t       kind;
        err_t        code;
        logic [1:0]  len;
        logic [20:0] cp;
    } cmd_t;

endpackage

// ----- rtl/core/json_string_unescaper_core.sv -----
// JSON string unescaper: one JSON byte per beat in, UTF-8 bytes and status out.
// Throughput: one input byte per cycle while the queue is not full; each UTF-8 byte is
// its own result beat, so a \u escape yielding up to four bytes holds the emitter while
// the queue absorbs commands. Results pass through the queue, then the output register.
// Reset: synchronous active-low aresetn clears parser phase, queue and output valid.
`include "assert_macros.svh"

module json_string_unescaper_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] out_kind
    output logic        m_tlast    // run_last
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_empty;
    jsu_pkg::cmd_t push_cmd;
    jsu_pkg::cmd_t head_cmd;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    jsu_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    jsu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The parser never pushes into a full queue.
    `JSU_ASSERT(a_no_push_when_full, aclk, aresetn, !(q_push && q_full))
    // Data and done beats carry no error code.
    `JSU_ASSERT(a_code_only_on_error, aclk, aresetn, (m_tvalid && m_tuser != jsu_pkg::KIND_ERROR) |-> (m_tdata[11:8] == 4'd0))
    // Done and error beats end the run of their byte.
    `JSU_ASSERT(a_status_is_last, aclk, aresetn, (m_tvalid && m_tuser != jsu_pkg::KIND_DATA) |-> m_tlast)
    // Reset empties the output register.
    `JSU_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

// ----- rtl/core/jsu_front.sv -----
// Parser: accepts JSON bytes, tracks string and escape state, issues commands.
module jsu_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] in_byte
    input  logic           s_tlast,
    input  logic           q_full,
    output logic           q_push,
    output jsu_pkg::cmd_t  q_cmd
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX,
        PH_PBS,
        PH_PU,
        PH_LOWHEX,
        PH_CLOSED,
        PH_DRAIN
    } phase_t;

    // Hex digit value; bit 4 set marks a non-hex byte.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b0, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Single-character escape value; bit 8 set marks no such escape.
    function automatic logic [8:0] esc_val(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h22:   r = 9'h022;
            8'h5C:   r = 9'h05C;
            8'h2F:   r = 9'h02F;
            8'h62:   r = 9'h008;
            8'h66:   r = 9'h00C;
            8'h6E:   r = 9'h00A;
            8'h72:   r = 9'h00D;
            8'h74:   r = 9'h009;
            default: r = 9'h100;
        endcase
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] acc_reg, acc_next;
    logic [9:0]  hs_reg, hs_next;

    logic          accept;
    jsu_pkg::err_t err;
    logic          closed;
    logic          emit;
    logic [20:0]   emit_cp;
    logic [1:0]    emit_len;
    logic [4:0]    hex;
    logic [8:0]    esc;
    logic [15:0]   acc_shift;
    logic [20:0]   pair_cp;
    logic          is_low;
    logic          is_high;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Decode one byte against the current phase.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        hs_next    = hs_reg;
        err        = jsu_pkg::ERR_NONE;
        closed     = 1'b0;
        emit       = 1'b0;
        emit_cp    = {13'd0, s_tdata};
        emit_len   = 2'd0;
        hex        = hex_val(s_tdata);
        esc        = esc_val(s_tdata);
        acc_shift  = {acc_reg[11:0], hex[3:0]};
        pair_cp    = 21'h10000 + {1'b0, hs_reg, acc_shift[9:0]};
        is_low     = (acc_shift[15:10] == 6'b110111);
        is_high    = (acc_shift[15:10] == 6'b110110);

        unique case (phase_reg) inside
            PH_IDLE: begin
                if (s_tdata == CH_SPACE || s_tdata == CH_TAB ||
                    s_tdata == CH_LF || s_tdata == CH_CR) begin
                    if (s_tlast) err = jsu_pkg::ERR_NO_QUOTE;
                end else if (s_tdata == CH_QUOTE) begin
                    phase_next = PH_STR;
                    if (s_tlast) err = jsu_pkg::ERR_UNTERMINATED;
                end else begin
                    err = jsu_pkg::ERR_NO_QUOTE;
                end
            end
            PH_STR: begin
                if (s_tdata == CH_QUOTE) begin
                    closed = 1'b1;
                end else if (s_tdata < 8'h20) begin
                    err = jsu_pkg::ERR_CONTROL;
                end else if (s_tdata == CH_BSL) begin
                    phase_next = PH_ESC;
                    if (s_tlast) err = jsu_pkg::ERR_ESC_INCOMPLETE;
                end else if (s_tlast) begin
                    err = jsu_pkg::ERR_UNTERMINATED;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_ESC: begin
                if (!esc[8]) begin
                    phase_next = PH_STR;
                    emit_cp    = {13'd0, esc[7:0]};
                    if (s_tlast) err = jsu_pkg::ERR_UNTERMINATED;
                    else emit = 1'b1;
                end else if (s_tdata == CH_U) begin
                    phase_next = PH_HEX;
                    cnt_next   = 2'd0;
                    acc_next   = 16'd0;
                    if (s_tlast) err = jsu_pkg::ERR_UNI_INCOMPLETE;
                end else begin
                    err = jsu_pkg::ERR_BAD_ESCAPE;
                end
            end
            PH_HEX: begin
                if (hex[4]) begin
                    err = jsu_pkg::ERR_NON_HEX;
                end else begin
                    acc_next = acc_shift;
                    if (cnt_reg == 2'd3) begin
                        cnt_next = 2'd0;
                        if (is_low) begin
                            err = jsu_pkg::ERR_UNPAIRED_LOW;
                        end else if (is_high) begin
                            hs_next    = acc_shift[9:0];
                            phase_next = PH_PBS;
                            if (s_tlast) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                        end else begin
                            phase_next = PH_STR;
                            emit_cp    = {5'd0, acc_shift};
                            if (acc_shift[15:7] == 9'd0) emit_len = 2'd0;
                            else if (acc_shift[15:11] == 5'd0) emit_len = 2'd1;
                            else emit_len = 2'd2;
                            if (s_tlast) err = jsu_pkg::ERR_UNTERMINATED;
                            else emit = 1'b1;
                        end
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                        if (s_tlast) err = jsu_pkg::ERR_UNI_INCOMPLETE;
                    end
                end
            end
            PH_PBS: begin
                if (s_tdata != CH_BSL || s_tlast) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                else phase_next = PH_PU;
            end
            PH_PU: begin
                if (s_tdata != CH_U || s_tlast) begin
                    err = jsu_pkg::ERR_UNPAIRED_HIGH;
                end else begin
                    phase_next = PH_LOWHEX;
                    cnt_next   = 2'd0;
                    acc_next   = 16'd0;
                end
            end
            PH_LOWHEX: begin
                if (hex[4]) begin
                    err = jsu_pkg::ERR_NON_HEX;
                end else begin
                    acc_next = acc_shift;
                    if (cnt_reg == 2'd3) begin
                        cnt_next = 2'd0;
                        if (!is_low) begin
                            err = jsu_pkg::ERR_BAD_PAIR;
                        end else begin
                            phase_next = PH_STR;
                            emit_cp    = pair_cp;
                            emit_len   = 2'd3;
                            if (s_tlast) err = jsu_pkg::ERR_UNTERMINATED;
                            else emit = 1'b1;
                        end
                    end else begin
                        cnt_next = cnt_reg + 2'd1;
                        if (s_tlast) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                    end
                end
            end
            PH_CLOSED, PH_DRAIN: begin
                // Swallow bytes until the end of the buffer.
                if (s_tlast) begin
                    phase_next = PH_IDLE;
                    cnt_next   = 2'd0;
                    acc_next   = 16'd0;
                    hs_next    = 10'd0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // Done and error override any data and settle the next phase.
        if (closed) begin
            phase_next = s_tlast ? PH_IDLE : PH_CLOSED;
            if (s_tlast) begin
                cnt_next = 2'd0;
                acc_next = 16'd0;
                hs_next  = 10'd0;
            end
        end else if (err != jsu_pkg::ERR_NONE) begin
            emit       = 1'b0;
            phase_next = s_tlast ? PH_IDLE : PH_DRAIN;
            cnt_next   = 2'd0;
            acc_next   = 16'd0;
            hs_next    = 10'd0;
        end

        q_cmd.cp   = emit_cp;
        q_cmd.len  = emit_len;
        q_cmd.code = err;
        q_cmd.kind = jsu_pkg::KIND_DATA;
        if (closed) begin
            q_cmd.kind = jsu_pkg::KIND_DONE;
            q_cmd.cp   = 21'd0;
            q_cmd.len  = 2'd0;
        end else if (err != jsu_pkg::ERR_NONE) begin
            q_cmd.kind = jsu_pkg::KIND_ERROR;
            q_cmd.cp   = 21'd0;
            q_cmd.len  = 2'd0;
        end
        q_push = accept && (closed || emit || (err != jsu_pkg::ERR_NONE));
    end

    // Hold parser state; advance on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 2'd0;
            acc_reg   <= 16'd0;
            hs_reg    <= 10'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            hs_reg    <= hs_next;
        end
    end

endmodule

// ----- rtl/core/jsu_cmd_fifo.sv -----
// Command queue between the parser and the UTF-8 emitter.
module jsu_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  jsu_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output jsu_pkg::cmd_t  head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    jsu_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign head_cmd = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Wrap pointers at the depth and track the fill level.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload without reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/jsu_back.sv -----
// Emitter: expands queued commands into UTF-8 result beats.
module jsu_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_empty,
    input  jsu_pkg::cmd_t  q_cmd,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [15:0]    m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]     m_tuser,   // [1:0] out_kind
    output logic           m_tlast    // run_last
);

    // UTF-8 byte number idx of a code point that takes len+1 bytes.
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] r;
        logic [1:0] rem;
        rem = len - idx;
        if (idx != 2'd0) begin
            case (rem)
                2'd0:    r = {2'b10, cp[5:0]};
                2'd1:    r = {2'b10, cp[11:6]};
                default: r = {2'b10, cp[17:12]};
            endcase
        end else begin
            case (len)
                2'd0:    r = cp[7:0];
                2'd1:    r = {3'b110, cp[10:6]};
                2'd2:    r = {4'b1110, cp[15:12]};
                default: r = {5'b11110, cp[20:18]};
            endcase
        end
        return r;
    endfunction

    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  code_reg, code_next;
    logic [1:0]  kind_reg, kind_next;
    logic        last_reg, last_next;
    logic        load;
    logic        at_end;

    assign load   = !valid_reg || m_tready;
    assign at_end = (idx_reg == q_cmd.len);
    assign q_pop  = load && !q_empty && at_end;

    // Refill the output register from the queue head, one byte a beat.
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        byte_next  = byte_reg;
        code_next  = code_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                byte_next = utf8_byte(q_cmd.cp, q_cmd.len, idx_reg);
                code_next = q_cmd.code;
                kind_next = q_cmd.kind;
                last_next = at_end;
                idx_next  = at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Hold payload; no reset needed.
    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        code_reg <= code_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'd0, code_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the JSON string unescaper: byte stream in, UTF-8 and status out.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 395;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;

    // Scanner position inside the JSON text
    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_STRING, SCAN_ESCAPE, SCAN_HEX, SCAN_PAIR_BSLASH,
        SCAN_PAIR_U, SCAN_LOW_HEX, SCAN_CLOSED, SCAN_DRAIN
    } scan_state_t;

    typedef struct {
        logic [7:0]     data;
        jsu_pkg::kind_t kind;
        jsu_pkg::err_t  code;
        logic           last;
    } utf8_beat_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } json_byte_t;

    // Predicts UTF-8 beats for each accepted JSON byte and checks them in order
    class unescape_scoreboard;
        scan_state_t  state;
        logic [1:0]   digits;
        logic [15:0]  unit;
        logic [9:0]   high_bits;
        utf8_beat_t   utf8_expected[$];
        int           mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            state     = SCAN_IDLE;
            digits    = '0;
            unit      = '0;
            high_bits = '0;
        endfunction

        function int digit_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return 16;
        endfunction

        function void put(ref utf8_beat_t beats[$], input logic [7:0] d,
                          input jsu_pkg::kind_t k, input jsu_pkg::err_t e);
            utf8_beat_t b;
            b.data = d;
            b.kind = k;
            b.code = e;
            b.last = 1'b0;
            beats = {beats, b};
        endfunction

        // Encode one code point as one to four UTF-8 bytes
        function void put_code_point(ref utf8_beat_t beats[$], input logic [20:0] cp);
            if (cp <= 21'h7F) begin
                put(beats, cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end else if (cp <= 21'h7FF) begin
                put(beats, 8'hC0 | cp[10:6], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[5:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end else if (cp <= 21'hFFFF) begin
                put(beats, 8'hE0 | cp[15:12], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[11:6], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[5:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end else begin
                put(beats, 8'hF0 | cp[20:18], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[17:12], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[11:6], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                put(beats, 8'h80 | cp[5:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            end
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            utf8_beat_t    beats[$];
            jsu_pkg::err_t err;
            bit            closed;
            int            v;
            logic [15:0]   acc;
            logic [7:0]    esc;
            err    = jsu_pkg::ERR_NONE;
            closed = 1'b0;
            acc    = unit;
            case (state)
                SCAN_IDLE: begin
                    if (b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
                        if (last) err = jsu_pkg::ERR_NO_QUOTE;
                    end else if (b == CH_QUOTE) begin
                        state = SCAN_STRING;
                        if (last) err = jsu_pkg::ERR_UNTERMINATED;
                    end else begin
                        err = jsu_pkg::ERR_NO_QUOTE;
                    end
                end
                SCAN_STRING: begin
                    if (b == CH_QUOTE) closed = 1'b1;
                    else if (b < 8'h20) err = jsu_pkg::ERR_CONTROL;
                    else if (b == CH_BSLASH) begin
                        state = SCAN_ESCAPE;
                        if (last) err = jsu_pkg::ERR_ESC_INCOMPLETE;
                    end else if (last) err = jsu_pkg::ERR_UNTERMINATED;
                    else put(beats, b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                end
                SCAN_ESCAPE: begin
                    v = 1;
                    case (b)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: esc = b;
                        "b": esc = 8'h08;
                        "f": esc = 8'h0C;
                        "n": esc = CH_LF;
                        "r": esc = CH_CR;
                        "t": esc = CH_TAB;
                        default: v = 0;
                    endcase
                    if (v != 0) begin
                        state = SCAN_STRING;
                        if (last) err = jsu_pkg::ERR_UNTERMINATED;
                        else put(beats, esc, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
                    end else if (b == CH_U) begin
                        state  = SCAN_HEX;
                        digits = '0;
                        unit   = '0;
                        if (last) err = jsu_pkg::ERR_UNI_INCOMPLETE;
                    end else begin
                        err = jsu_pkg::ERR_BAD_ESCAPE;
                    end
                end
                SCAN_HEX, SCAN_LOW_HEX: begin
                    v = digit_of(b);
                    if (v > 15) begin
                        err = jsu_pkg::ERR_NON_HEX;
                    end else begin
                        acc  = {acc[11:0], v[3:0]};
                        unit = acc;
                        if (digits != 2'd3) begin
                            digits = digits + 2'd1;
                            if (last) begin
                                err = (state == SCAN_HEX) ? jsu_pkg::ERR_UNI_INCOMPLETE
                                                          : jsu_pkg::ERR_UNPAIRED_HIGH;
                            end
                        end else begin
                            digits = '0;
                            if (state == SCAN_LOW_HEX) begin
                                // second half of a pair must be a low surrogate
                                if (acc < LOW_FIRST || acc > LOW_LAST) begin
                                    err = jsu_pkg::ERR_BAD_PAIR;
                                end else begin
                                    state = SCAN_STRING;
                                    if (last) err = jsu_pkg::ERR_UNTERMINATED;
                                    else put_code_point(beats, 21'h10000
                                                        + {1'b0, high_bits, 10'b0}
                                                        + acc[9:0]);
                                end
                            end else if (acc >= LOW_FIRST && acc <= LOW_LAST) begin
                                err = jsu_pkg::ERR_UNPAIRED_LOW;
                            end else if (acc >= HIGH_FIRST && acc <= HIGH_LAST) begin
                                high_bits = acc[9:0];
                                state     = SCAN_PAIR_BSLASH;
                                if (last) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                            end else begin
                                state = SCAN_STRING;
                                if (last) err = jsu_pkg::ERR_UNTERMINATED;
                                else put_code_point(beats, {5'b0, acc});
                            end
                        end
                    end
                end
                SCAN_PAIR_BSLASH: begin
                    if (b != CH_BSLASH || last) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                    else state = SCAN_PAIR_U;
                end
                SCAN_PAIR_U: begin
                    if (b != CH_U || last) err = jsu_pkg::ERR_UNPAIRED_HIGH;
                    else begin
                        state  = SCAN_LOW_HEX;
                        digits = '0;
                        unit   = '0;
                    end
                end
                default: begin
                    // closed or draining: swallow bytes until the buffer ends
                    if (last) clear();
                    return;
                end
            endcase

            if (closed) begin
                put(beats, 8'h00, jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
                if (last) clear();
                else state = SCAN_CLOSED;
            end else if (err != jsu_pkg::ERR_NONE) begin
                // an error replaces anything the byte would have decoded
                beats.delete();
                put(beats, 8'h00, jsu_pkg::KIND_ERROR, err);
                clear();
                if (!last) state = SCAN_DRAIN;
            end
            if (beats.size() > 0) beats[beats.size() - 1].last = 1'b1;
            utf8_expected = {utf8_expected, beats};
        endfunction

        function void check_beat(logic [15:0] tdata, logic [1:0] tuser, logic tlast);
            utf8_beat_t e;
            if (utf8_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: unexpected beat tdata=%h tuser=%0d tlast=%b",
                             $realtime, tdata, tuser, tlast);
                return;
            end
            e = utf8_expected.pop_front();
            if (tdata[7:0] !== e.data || tdata[11:8] !== e.code || tdata[15:12] !== 4'h0
                    || tuser !== e.kind || tlast !== e.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%t: beat mismatch exp byte=%h code=%0d kind=%0d last=%b",
                             $realtime, e.data, e.code, e.kind, e.last,
                             " got byte=%h code=%0d pad=%h kind=%0d last=%b",
                             tdata[7:0], tdata[11:8], tdata[15:12], tuser, tlast);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;  // [7:0] in_byte
    logic        s_tlast  = 1'b0;   // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] out_byte, [11:8] error_code, [15:12] zero
    logic [1:0]  m_tuser;           // [1:0] out_kind
    logic        m_tlast;           // run_last

    unescape_scoreboard sb = new();
    json_byte_t         json_bytes[$];
    int                 bytes_sent = 0;
    int                 cycles = 0;

    json_string_unescaper_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Queue one text buffer, marking its final byte
    task automatic push_text(input logic [7:0] txt[$]);
        json_byte_t jb;
        foreach (txt[i]) begin
            jb.data = txt[i];
            jb.last = (i == txt.size() - 1);
            json_bytes = {json_bytes, jb};
        end
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "A" : "a") + n - 4'd10;
    endfunction

    task automatic add_unit(ref logic [7:0] txt[$], input logic [15:0] u);
        txt = {txt, CH_BSLASH, CH_U};
        for (int i = 3; i >= 0; i--) txt = {txt, hex_char(u[i*4 +: 4])};
    endtask

    function automatic logic [15:0] high_unit();
        case ($urandom_range(0, 3))
            0: return HIGH_FIRST;
            1: return HIGH_LAST;
            default: return HIGH_FIRST | 16'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    // Build one mostly well-formed string with random content, sometimes broken
    task automatic build_text();
        logic [7:0]  txt[$];
        logic [7:0]  c;
        logic [7:0]  esc_letters[8];
        logic [7:0]  ws_chars[4];
        logic [15:0] lo_bound[4];
        logic [15:0] hi_bound[4];
        logic [20:0] cp;
        int          r;
        int          cut;
        esc_letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};
        ws_chars    = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        lo_bound    = '{16'h0000, 16'h0080, 16'h0800, 16'hE000};
        hi_bound    = '{16'h007F, 16'h07FF, 16'hD7FF, 16'hFFFF};
        repeat ($urandom_range(0, 2)) txt = {txt, ws_chars[$urandom_range(0, 3)]};
        txt = {txt, CH_QUOTE};
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 19);
            if (r < 8) begin
                txt = {txt, plain_char()};
            end else if (r < 12) begin
                txt = {txt, CH_BSLASH, esc_letters[$urandom_range(0, 7)]};
            end else if (r < 15) begin
                // BMP code point, range ends favored
                r = $urandom_range(0, 3);
                case ($urandom_range(0, 3))
                    0: cp = {5'b0, lo_bound[r]};
                    1: cp = {5'b0, hi_bound[r]};
                    default: cp = 21'($urandom_range(lo_bound[r], hi_bound[r]));
                endcase
                add_unit(txt, cp[15:0]);
            end else if (r < 17) begin
                add_unit(txt, high_unit());
                case ($urandom_range(0, 3))
                    0: add_unit(txt, LOW_FIRST);
                    1: add_unit(txt, LOW_LAST);
                    default: add_unit(txt, LOW_FIRST | 16'($urandom_range(0, 1023)));
                endcase
            end else if (r == 17) begin
                // broken surrogate usage
                case ($urandom_range(0, 3))
                    0: add_unit(txt, LOW_FIRST | 16'($urandom_range(0, 1023)));
                    1: begin
                        add_unit(txt, high_unit());
                        txt = {txt, plain_char()};
                    end
                    2: begin
                        add_unit(txt, high_unit());
                        add_unit(txt, $urandom_range(0, 1)
                                      ? 16'($urandom_range(0, HIGH_LAST))
                                      : 16'($urandom_range(16'hE000, 16'hFFFF)));
                    end
                    default: begin
                        add_unit(txt, high_unit());
                        txt = {txt, CH_BSLASH, esc_letters[$urandom_range(0, 7)]};
                    end
                endcase
            end else begin
                // malformed content inside the string
                case ($urandom_range(0, 2))
                    0: txt = {txt, 8'($urandom_range(0, 31))};
                    1: begin
                        do c = 8'($urandom_range(0, 255));
                        while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_U,
                                         "b", "f", "n", "r", "t"});
                        txt = {txt, CH_BSLASH, c};
                    end
                    default: begin
                        txt = {txt, CH_BSLASH, CH_U};
                        repeat ($urandom_range(0, 3))
                            txt = {txt, hex_char(4'($urandom_range(0, 15)))};
                        do c = 8'($urandom_range(0, 255)); while (sb.digit_of(c) <= 15);
                        txt = {txt, c};
                    end
                endcase
            end
        end
        txt = {txt, CH_QUOTE};
        repeat ($urandom_range(0, 2)) txt = {txt, 8'($urandom_range(0, 255))};
        // occasionally cut the buffer short or corrupt one byte
        case ($urandom_range(0, 9))
            0: begin
                cut = $urandom_range(1, txt.size());
                while (txt.size() > cut) void'(txt.pop_back());
            end
            1: txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        push_text(txt);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        // idle at random outside the steady window
        while (!(bytes_sent >= 60 && bytes_sent < 200) && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    // Reset, stimulus and end of run
    initial begin
        logic [7:0] noise[$];
        int         directed_count;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: \u0000 closed on the last byte, high bytes, truncation,
        // no quote with drain, bytes after close, lone backslash, control byte
        push_text('{CH_QUOTE, CH_BSLASH, CH_U, "0", "0", "0", "0", CH_QUOTE});
        push_text('{CH_SPACE, CH_QUOTE, 8'hFF, 8'h80, "a"});
        push_text('{"x", "y"});
        push_text('{CH_QUOTE, CH_QUOTE, "z"});
        push_text('{CH_QUOTE, CH_BSLASH});
        push_text('{CH_QUOTE, 8'h00, "."});
        push_text('{CH_TAB, CH_CR, CH_LF});
        directed_count = json_bytes.size();

        while (json_bytes.size() < directed_count + RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
                noise.delete();
                repeat ($urandom_range(1, 5)) noise = {noise, 8'($urandom_range(0, 255))};
                push_text(noise);
            end else begin
                build_text();
            end
        end

        @(posedge aclk);
        foreach (json_bytes[i]) send_byte(json_bytes[i].data, json_bytes[i].last);
        s_tvalid <= 1'b0;

        while (sb.utf8_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, one stretch always ready
    initial begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held && bytes_sent >= 60) begin
                held      = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (bytes_sent >= 250 && bytes_sent < 330) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= 35);
            end
            @(posedge aclk);
        end
    end

    // Check every accepted result beat
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser, m_tlast);
    end

    // Give up on a hung run
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

endmodule
